// ===== hw/rtl/stq_pkg.sv =====
`default_nettype none

package stq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int TIME_W        = 48;
    localparam int ID_W          = 16;
    localparam int TAG_W         = 16;
    localparam int MODE_W        = 2;
    localparam int KIND_W        = 2;
    localparam int MAX_FIRE      = 16;
    localparam int FIRE_CNT_W    = $clog2(MAX_FIRE);

    localparam logic [MODE_W-1:0] MODE_DELAY  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ABS    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd3;

    localparam logic [KIND_W-1:0] KIND_INSERTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVED  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd3;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE,
        OP_POP
    } cell_op_t;

    typedef struct packed {
        logic [TIME_W-1:0] dl;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
    } cell_data_t;

    // Broadcast to every cell of the chain
    typedef struct packed {
        cell_op_t          op;
        logic [TIME_W-1:0] when;
        logic [ID_W-1:0]   id;
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   tid;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stq_cell.sv =====
`default_nettype none

module stq_cell (
    input  wire                      clk,
    input  wire                      valid,
    input  wire stq_pkg::cell_cmd_t  cmd,
    input  wire stq_pkg::cell_data_t left_data,
    input  wire                      left_cond,
    input  wire                      seen_in,
    input  wire stq_pkg::cell_data_t right_data,
    output stq_pkg::cell_data_t      data,
    output logic                     cond,
    output logic                     seen_out
);
    import stq_pkg::*;

    cell_data_t data_reg;
    cell_data_t data_next;
    cell_data_t new_data;

    // Insert point: first free slot or first entry due at or after the new one
    assign cond     = !valid || (data_reg.dl >= cmd.when);
    assign seen_out = seen_in || (valid && (data_reg.id == cmd.tid));
    assign data     = data_reg;

    always_comb
    begin
        new_data.dl  = cmd.when;
        new_data.id  = cmd.id;
        new_data.tag = cmd.tag;
        data_next    = data_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (left_cond)
                    data_next = left_data;
                else if (cond)
                    data_next = new_data;
            end
            OP_REMOVE:
            begin
                if (seen_out)
                    data_next = right_data;
            end
            OP_POP:
                data_next = right_data;
            default:
                data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_timer_event_queue_top.sv =====
// Sorted timer event queue.
//
// Input channel (in_valid/in_ready) carries one command per transfer: mode,
// time_value, action_tag, target_id. Output channel (out_valid/out_ready)
// carries results: kind, entry_id, tag_out, last. cfg_we/cfg_wdata write the
// enable bit; write it only while the block is idle.
//
// Pending entries live in a row of DEPTH cells kept sorted by deadline, the
// earliest at cell 0. Insert shifts later entries one cell right, remove and
// expiry shift entries one cell left, all cells in the same cycle.
//
// Flow: a command is taken on its transfer and applied in the S_EXEC state,
// which waits for a free output register and loads the result into it. A
// tick moves to S_FIRE; when nothing fires (disabled or nothing due) it goes
// back to idle with no result, else it expires the due entries from the head
// (up to 16), each expiry waiting for a free output register. in_ready is high
// only between commands.
// Reset clears the queue (occupancy 0), the id counter and the tick count and
// disables firing. A stalled receiver holds the output register; the block
// then holds its pending step until the result transfers.
`default_nettype none

module sorted_timer_event_queue_top #(
    parameter int DEPTH = stq_pkg::DEPTH_DEFAULT
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         cfg_we,
    input  wire                         cfg_wdata,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  wire [stq_pkg::MODE_W-1:0]   mode,
    input  wire [stq_pkg::TIME_W-1:0]   time_value,
    input  wire [stq_pkg::TAG_W-1:0]    action_tag,
    input  wire [stq_pkg::ID_W-1:0]     target_id,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [stq_pkg::KIND_W-1:0]  kind,
    output logic [stq_pkg::ID_W-1:0]    entry_id,
    output logic [stq_pkg::TAG_W-1:0]   tag_out,
    output logic                        last
);
    import stq_pkg::*;

    localparam int OCC_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FIRE
    } state_t;

    state_t                 state_reg, state_next;
    logic [MODE_W-1:0]      mode_reg, mode_next;
    logic [TIME_W-1:0]      when_reg, when_next;
    logic [TAG_W-1:0]       tag_reg, tag_next;
    logic [ID_W-1:0]        tid_reg, tid_next;
    logic [TIME_W-1:0]      now_reg, now_next;
    logic [ID_W-1:0]        next_id_reg, next_id_next;
    logic [OCC_W-1:0]       occ_reg, occ_next;
    logic                   enable_reg, enable_next;
    logic [FIRE_CNT_W-1:0]  fire_cnt_reg, fire_cnt_next;
    logic                   out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]      kind_reg, kind_next;
    logic [ID_W-1:0]        entry_id_reg, entry_id_next;
    logic [TAG_W-1:0]       tag_out_reg, tag_out_next;
    logic                   last_reg, last_next;

    cell_cmd_t              cmd;
    cell_data_t             data_w [DEPTH];
    logic                   valid_w [DEPTH];
    logic                   cond_w [DEPTH];
    logic                   seen_w [DEPTH];

    logic [TIME_W:0]        delay_sum;
    logic                   out_free;
    logic                   full;
    logic                   head_due;
    logic                   second_due;
    logic                   fire_last;
    logic                   load_out;

    // Cell chain: each cell sees its neighbors' data and flags
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        cell_data_t left_d;
        cell_data_t right_d;
        logic       left_c;
        logic       seen_i;

        assign valid_w[i] = (occ_reg > OCC_W'(i));

        if (i == 0)
        begin : g_head
            assign left_d = '0;
            assign left_c = 1'b0;
            assign seen_i = 1'b0;
        end
        else
        begin : g_body
            assign left_d = data_w[i-1];
            assign left_c = cond_w[i-1];
            assign seen_i = seen_w[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_d = '0;
        end
        else
        begin : g_mid
            assign right_d = data_w[i+1];
        end

        stq_cell u_cell (
            .clk        (clk),
            .valid      (valid_w[i]),
            .cmd        (cmd),
            .left_data  (left_d),
            .left_cond  (left_c),
            .seen_in    (seen_i),
            .right_data (right_d),
            .data       (data_w[i]),
            .cond       (cond_w[i]),
            .seen_out   (seen_w[i])
        );
    end

    // Relative deadline, saturated at the top of the time range
    assign delay_sum  = {1'b0, now_reg} + {1'b0, time_value};
    assign out_free   = !out_valid_reg || out_ready;
    assign full       = (occ_reg == OCC_W'(DEPTH));
    assign head_due   = valid_w[0] && (data_w[0].dl <= now_reg);
    assign second_due = valid_w[1] && (data_w[1].dl <= now_reg);
    assign fire_last  = (fire_cnt_reg == FIRE_CNT_W'(MAX_FIRE - 1)) || !second_due;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        when_next      = when_reg;
        tag_next       = tag_reg;
        tid_next       = tid_reg;
        now_next       = now_reg;
        next_id_next   = next_id_reg;
        occ_next       = occ_reg;
        enable_next    = enable_reg;
        fire_cnt_next  = fire_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        kind_next      = kind_reg;
        entry_id_next  = entry_id_reg;
        tag_out_next   = tag_out_reg;
        last_next      = last_reg;
        load_out       = 1'b0;

        cmd.op   = OP_HOLD;
        cmd.when = when_reg;
        cmd.id   = next_id_reg + 1'b1;
        cmd.tag  = tag_reg;
        cmd.tid  = tid_reg;

        if (cfg_we)
            enable_next = cfg_wdata;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    tag_next  = action_tag;
                    tid_next  = target_id;
                    if (mode == MODE_DELAY)
                        when_next = delay_sum[TIME_W] ? '1 : delay_sum[TIME_W-1:0];
                    else
                        when_next = time_value;
                    if (mode == MODE_TICK)
                    begin
                        now_next      = now_reg + 1'b1;
                        fire_cnt_next = '0;
                        state_next    = S_FIRE;
                    end
                    else
                        state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    load_out     = 1'b1;
                    tag_out_next = '0;
                    last_next    = 1'b1;
                    if (mode_reg == MODE_REMOVE)
                    begin
                        cmd.op        = OP_REMOVE;
                        kind_next     = KIND_REMOVED;
                        entry_id_next = tid_reg;
                        if (seen_w[DEPTH-1])
                            occ_next = occ_reg - 1'b1;
                    end
                    else if (full)
                    begin
                        kind_next     = KIND_FULL;
                        entry_id_next = '0;
                    end
                    else
                    begin
                        cmd.op        = OP_INSERT;
                        kind_next     = KIND_INSERTED;
                        entry_id_next = cmd.id;
                        next_id_next  = cmd.id;
                        occ_next      = occ_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FIRE:
            begin
                if (!enable_reg || !head_due)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    load_out      = 1'b1;
                    cmd.op        = OP_POP;
                    kind_next     = KIND_EXPIRED;
                    entry_id_next = data_w[0].id;
                    tag_out_next  = data_w[0].tag;
                    last_next     = fire_last;
                    occ_next      = occ_reg - 1'b1;
                    fire_cnt_next = fire_cnt_reg + 1'b1;
                    if (fire_last)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        if (load_out)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_DELAY;
            when_reg      <= '0;
            tag_reg       <= '0;
            tid_reg       <= '0;
            now_reg       <= '0;
            next_id_reg   <= '0;
            occ_reg       <= '0;
            enable_reg    <= 1'b0;
            fire_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_INSERTED;
            entry_id_reg  <= '0;
            tag_out_reg   <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            when_reg      <= when_next;
            tag_reg       <= tag_next;
            tid_reg       <= tid_next;
            now_reg       <= now_next;
            next_id_reg   <= next_id_next;
            occ_reg       <= occ_next;
            enable_reg    <= enable_next;
            fire_cnt_reg  <= fire_cnt_next;
            out_valid_reg <= out_valid_next;
            kind_reg      <= kind_next;
            entry_id_reg  <= entry_id_next;
            tag_out_reg   <= tag_out_next;
            last_reg      <= last_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign entry_id  = entry_id_reg;
    assign tag_out   = tag_out_reg;
    assign last      = last_reg;

    // Occupancy never runs past the chain length
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy beyond depth");

    // One command at a time: a transfer closes the input until it is done
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a command is in progress");

    // A rejected insert leaves the queue and the id counter alone
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) && out_free && (mode_reg != MODE_REMOVE) && full
        |=> $stable(occ_reg) && $stable(next_id_reg))
        else $error("full insert changed the queue");

    // Every expiry drops exactly one entry
    a_fire_pop: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && (kind_next == KIND_EXPIRED)
        |=> occ_reg == $past(occ_reg) - 1'b1)
        else $error("expiry did not drop the head");

    // A result that is not the last one is followed by more expiries
    a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !last_reg |-> state_reg == S_FIRE)
        else $error("non-last result without a pending expiry");

endmodule

`default_nettype wire
